// ===== rtl/core/vp9_reference_surface_manager_assert.svh =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager assertion macros
// Concurrent assertion wrappers shared by the RTL of the surface manager.
// ----------------------------------------------------------------------------
`ifndef VP9_REFERENCE_SURFACE_MANAGER_ASSERT_SVH
`define VP9_REFERENCE_SURFACE_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
`define VRSM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vrsm assertion failed");
`define VRSM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("vrsm reset check failed");
`else
`define VRSM_ASSERT(lbl, clk, rst, prop)
`define VRSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/vrsm_pkg.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager package
// Widths, codes, types and helpers shared by the surface manager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vrsm_pkg;

   localparam int MAX_SURFACES = 32;
   localparam int REF_SLOTS    = 8;
   localparam int CAP_COUNT    = (MAX_SURFACES > 32) ? 32 : MAX_SURFACES;
   localparam int MIN_COUNT    = 2;
   localparam int RESET_COUNT  = 8;

   localparam int CNT_W       = 6;
   localparam int SURF_W      = 5;
   localparam int SLOT_IDX_W  = 3;
   localparam int SLOT_DATA_W = 8;
   localparam int DIM_W       = 14;
   localparam int FNUM_W      = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   localparam logic [SLOT_DATA_W-1:0] NO_SURFACE = 8'hFF;
   localparam logic [DIM_W-1:0]       MAX_DIM    = 14'd8192;

   localparam logic [SURF_W-1:0] CURSOR_RESET =
      SURF_W'(((RESET_COUNT > CAP_COUNT) ? CAP_COUNT : RESET_COUNT) - 1);

   localparam logic [CMD_W-1:0] CMD_DECODE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SHOW   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_DECODE,
      KIND_BAD_SIZE,
      KIND_SHOW,
      KIND_FLUSH,
      KIND_NONE
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      kind_type                kind;
      logic                    key_frame;
      logic                    is_intra;
      logic [SLOT_IDX_W-1:0]   ref_idx0;
      logic [SLOT_IDX_W-1:0]   ref_idx1;
      logic [SLOT_IDX_W-1:0]   ref_idx2;
      logic [REF_SLOTS-1:0]    refresh_mask;
      logic [DIM_W-1:0]        frame_width;
      logic [DIM_W-1:0]        frame_height;
      logic                    show_decoded;
      logic [SLOT_IDX_W-1:0]   show_slot;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SURF_W-1:0]       surface;
      logic                    display;
      logic [SLOT_DATA_W-1:0]  ref_surface0;
      logic [SLOT_DATA_W-1:0]  ref_surface1;
      logic [SLOT_DATA_W-1:0]  ref_surface2;
      logic [FNUM_W-1:0]       frame_number;
   } result_type;

   localparam result_type RESULT_IDLE = '{
      status:       STATUS_OK,
      surface:      '0,
      display:      1'b0,
      ref_surface0: NO_SURFACE,
      ref_surface1: NO_SURFACE,
      ref_surface2: NO_SURFACE,
      frame_number: '0
   };

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] value);
      logic [CNT_W-1:0] r;
      r = value;
      if (r > CNT_W'(CAP_COUNT)) begin
         r = CNT_W'(CAP_COUNT);
      end
      if (r < CNT_W'(MIN_COUNT)) begin
         r = CNT_W'(MIN_COUNT);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vrsm_if.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager channels
// Valid/ready channels for frame header words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrsm_req_if;
   import vrsm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic                  key_frame;
   logic                  is_intra;
   logic [SLOT_IDX_W-1:0] ref_idx0;
   logic [SLOT_IDX_W-1:0] ref_idx1;
   logic [SLOT_IDX_W-1:0] ref_idx2;
   logic [REF_SLOTS-1:0]  refresh_mask;
   logic [DIM_W-1:0]      frame_width;
   logic [DIM_W-1:0]      frame_height;
   logic                  show_decoded;
   logic [SLOT_IDX_W-1:0] show_slot;

   modport source (
      output valid, cmd, key_frame, is_intra, ref_idx0, ref_idx1, ref_idx2,
             refresh_mask, frame_width, frame_height, show_decoded, show_slot,
      input  ready
   );
   modport sink (
      input  valid, cmd, key_frame, is_intra, ref_idx0, ref_idx1, ref_idx2,
             refresh_mask, frame_width, frame_height, show_decoded, show_slot,
      output ready
   );
endinterface

interface vrsm_rsp_if;
   import vrsm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SURF_W-1:0]      surface;
   logic                   display;
   logic [SLOT_DATA_W-1:0] ref_surface0;
   logic [SLOT_DATA_W-1:0] ref_surface1;
   logic [SLOT_DATA_W-1:0] ref_surface2;
   logic [FNUM_W-1:0]      frame_number;

   modport source (
      output valid, status, surface, display, ref_surface0, ref_surface1,
             ref_surface2, frame_number,
      input  ready
   );
   modport sink (
      input  valid, status, surface, display, ref_surface0, ref_surface1,
             ref_surface2, frame_number,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/vrsm_front.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager front end
// Accepts header words and classifies them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module vrsm_front (
   vrsm_req_if.sink             req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output vrsm_pkg::entry_type  push_data
);
   import vrsm_pkg::*;

   logic size_bad;

   assign size_bad = (req.frame_width == '0) || (req.frame_height == '0) ||
                     (req.frame_width > MAX_DIM) || (req.frame_height > MAX_DIM);

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_data.key_frame    = req.key_frame;
      push_data.is_intra     = req.is_intra;
      push_data.ref_idx0     = req.ref_idx0;
      push_data.ref_idx1     = req.ref_idx1;
      push_data.ref_idx2     = req.ref_idx2;
      push_data.refresh_mask = req.refresh_mask;
      push_data.frame_width  = req.frame_width;
      push_data.frame_height = req.frame_height;
      push_data.show_decoded = req.show_decoded;
      push_data.show_slot    = req.show_slot;
      case (req.cmd)
         CMD_DECODE: begin
            push_data.kind = size_bad ? KIND_BAD_SIZE : KIND_DECODE;
         end
         CMD_SHOW: begin
            push_data.kind = KIND_SHOW;
         end
         CMD_FLUSH: begin
            push_data.kind = KIND_FLUSH;
         end
         default: begin
            // The unused command changes nothing and answers like a flush.
            push_data.kind = KIND_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/vrsm_queue.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vp9_reference_surface_manager_assert.svh"

module vrsm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  vrsm_pkg::entry_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output vrsm_pkg::entry_type  pop_data
);
   import vrsm_pkg::*;

   entry_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = count_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `VRSM_ASSERT(a_count_bound, clock, reset, count_ff <= QUEUE_CW'(QUEUE_DEPTH))
   `VRSM_ASSERT(a_pop_order, clock, reset, pop && !push |=> count_ff == $past(count_ff) - 1'b1)
   `VRSM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> count_ff == '0)

endmodule

`default_nettype wire

// ===== rtl/core/vrsm_back.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager back end
// Holds the slot map, picks and commits surfaces for decodes and reports a result for each entry.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vp9_reference_surface_manager_assert.svh"

module vrsm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [vrsm_pkg::CNT_W-1:0]  csr_wr_data,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  vrsm_pkg::entry_type         q_data,
   vrsm_rsp_if.source                  rsp
);
   import vrsm_pkg::*;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       n;
   logic [SLOT_DATA_W-1:0] slot_ff [REF_SLOTS];
   logic [SLOT_DATA_W-1:0] slot_in [REF_SLOTS];
   logic [SURF_W-1:0]      cursor_ff, cursor_in;
   logic [SURF_W-1:0]      cand_ff, cand_in, cand_next;
   logic [SURF_W-1:0]      start_ff, start_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;
   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [FNUM_W-1:0]      fcount_ff, fcount_in, fcount_inc;
   entry_type              item_ff, item_in;
   result_type             rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free, held, size_chg, size_err, decode_go;
   logic                   rem_big, last_step;
   logic [SLOT_DATA_W-1:0] shown;

   assign n          = eff_count(count_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign size_chg   = (item_ff.frame_width != width_ff) ||
                       (item_ff.frame_height != height_ff);
   assign size_err   = (item_ff.kind == KIND_BAD_SIZE) ||
                       ((item_ff.kind == KIND_DECODE) && size_chg && !item_ff.key_frame);
   assign decode_go  = (item_ff.kind == KIND_DECODE) && !size_err;
   assign rem_big    = rem_ff >= n;
   assign last_step  = (steps_ff + CNT_W'(1)) == n;
   assign cand_next  = ((CNT_W'(cand_ff) + CNT_W'(1)) == n) ? '0 : cand_ff + SURF_W'(1);
   assign shown      = slot_ff[item_ff.show_slot];
   assign fcount_inc = (fcount_ff == '1) ? FNUM_W'(1) : fcount_ff + FNUM_W'(1);

   always_comb begin
      held = 1'b0;
      for (int i = 0; i < REF_SLOTS; i++) begin
         if (slot_ff[i] == SLOT_DATA_W'(cand_ff)) begin
            held = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (decode_go) begin
               state_in = ST_MOD;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MOD: begin
            if (!rem_big) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!held || last_step) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_ready      = state_ff == ST_IDLE;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      slot_in      = slot_ff;
      cursor_in    = cursor_ff;
      cand_in      = cand_ff;
      start_in     = start_ff;
      rem_in       = rem_ff;
      steps_in     = steps_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      fcount_in    = fcount_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in = q_data;
            end
         end
         ST_EXEC: begin
            if (decode_go) begin
               if (size_chg) begin
                  // A new size on a keyframe empties the map and restarts the round robin.
                  for (int i = 0; i < REF_SLOTS; i++) begin
                     slot_in[i] = NO_SURFACE;
                  end
                  width_in  = item_ff.frame_width;
                  height_in = item_ff.frame_height;
                  rem_in    = '0;
               end else begin
                  rem_in = CNT_W'(cursor_ff) + CNT_W'(1);
               end
            end else if (out_free) begin
               rsp_in       = RESULT_IDLE;
               rsp_valid_in = 1'b1;
               case (item_ff.kind)
                  KIND_SHOW: begin
                     if ((shown == NO_SURFACE) || (shown >= SLOT_DATA_W'(n))) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_in.surface = shown[SURF_W-1:0];
                        rsp_in.display = 1'b1;
                     end
                  end
                  KIND_FLUSH: begin
                     for (int i = 0; i < REF_SLOTS; i++) begin
                        slot_in[i] = NO_SURFACE;
                     end
                  end
                  KIND_NONE: begin
                  end
                  default: begin
                     rsp_in.status = STATUS_SIZE;
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (rem_big) begin
               rem_in = rem_ff - n;
            end else begin
               cand_in  = rem_ff[SURF_W-1:0];
               start_in = rem_ff[SURF_W-1:0];
               steps_in = '0;
            end
         end
         ST_SCAN: begin
            if (held) begin
               if (last_step) begin
                  cand_in = start_ff;
               end else begin
                  cand_in  = cand_next;
                  steps_in = steps_ff + CNT_W'(1);
               end
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cursor_in           = cand_ff;
               fcount_in           = fcount_inc;
               rsp_in              = RESULT_IDLE;
               rsp_in.surface      = cand_ff;
               rsp_in.display      = item_ff.show_decoded;
               rsp_in.frame_number = fcount_inc;
               if (!item_ff.is_intra) begin
                  rsp_in.ref_surface0 = slot_ff[item_ff.ref_idx0];
                  rsp_in.ref_surface1 = slot_ff[item_ff.ref_idx1];
                  rsp_in.ref_surface2 = slot_ff[item_ff.ref_idx2];
               end
               rsp_valid_in = 1'b1;
               for (int i = 0; i < REF_SLOTS; i++) begin
                  if (item_ff.refresh_mask[i]) begin
                     slot_in[i] = SLOT_DATA_W'(cand_ff);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(RESET_COUNT);
         cursor_ff    <= CURSOR_RESET;
         width_ff     <= '0;
         height_ff    <= '0;
         fcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REF_SLOTS; i++) begin
            slot_ff[i] <= NO_SURFACE;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         fcount_ff    <= fcount_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
      cand_ff  <= cand_in;
      start_ff <= start_in;
      rem_ff   <= rem_in;
      steps_ff <= steps_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_ff.status;
   assign rsp.surface      = rsp_ff.surface;
   assign rsp.display      = rsp_ff.display;
   assign rsp.ref_surface0 = rsp_ff.ref_surface0;
   assign rsp.ref_surface1 = rsp_ff.ref_surface1;
   assign rsp.ref_surface2 = rsp_ff.ref_surface2;
   assign rsp.frame_number = rsp_ff.frame_number;

   `VRSM_ASSERT(a_scan_in_range, clock, reset, state_ff == ST_SCAN |-> CNT_W'(cand_ff) < n && steps_ff < n)
   `VRSM_ASSERT(a_commit_number, clock, reset, state_ff == ST_COMMIT && out_free |=> fcount_ff != '0 && rsp_valid_ff)
   `VRSM_ASSERT(a_commit_cursor, clock, reset, state_ff == ST_COMMIT && out_free |=> CNT_W'(cursor_ff) < n)
   `VRSM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE && !rsp_valid_ff)

endmodule

`default_nettype wire

// ===== rtl/core/vp9_reference_surface_manager.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager
// Tracks the surfaces held by the eight reference slots and assigns decode
// surfaces to new frames.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  req_ch    in         valid/ready        one parsed frame header command
//  rsp_ch    out        valid/ready        one result word per command
//  csr_*     in         write enable only  surface count register
//
// Show, flush and rejected decodes are answered from the execute state.
// A decode makes m reductions of cursor plus one below the surface count (one
// when the cursor wraps, more only after the count was lowered), then k scan
// steps of the slot comparator, one surface per cycle, 1 to surface count,
// and then commits.
// Reset is synchronous; the slot map is empty in the first cycle after it.
// A two-entry queue keeps taking words, until it is full, while a result waits
// in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vp9_reference_surface_manager (
   input  logic                        clock,
   input  logic                        reset,
   vrsm_req_if.sink                    req_ch,
   vrsm_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [vrsm_pkg::CNT_W-1:0]  csr_wr_data
);
   import vrsm_pkg::*;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_data, pop_data;

   vrsm_front u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   vrsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vrsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (pop_valid),
      .q_ready     (pop_ready),
      .q_data      (pop_data),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// VP9 reference surface manager testbench
// Sends parsed frame header words to the surface manager with random source
// gaps and sink stalls. A local model of the slot map, cursor, coded size and
// frame counter predicts every result word, and each field is compared. The
// surface count register is changed between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import vrsm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT       = 4000;
   localparam int SETTLE_CYCLES    = 100;
   localparam int RANDOM_PER_PHASE = 60;
   localparam int PHASES           = 12;
   localparam int DIM_CEILING      = (1 << DIM_W) - 1;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic                  key_frame;
      logic                  is_intra;
      logic [SLOT_IDX_W-1:0] ref_idx0;
      logic [SLOT_IDX_W-1:0] ref_idx1;
      logic [SLOT_IDX_W-1:0] ref_idx2;
      logic [REF_SLOTS-1:0]  refresh_mask;
      logic [DIM_W-1:0]      frame_width;
      logic [DIM_W-1:0]      frame_height;
      logic                  show_decoded;
      logic [SLOT_IDX_W-1:0] show_slot;
   } header_word_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   vrsm_req_if req_ch();
   vrsm_rsp_if rsp_ch();

   vp9_reference_surface_manager uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [SLOT_DATA_W-1:0] slot_surface [REF_SLOTS];
   logic [SURF_W-1:0]      rr_cursor;
   logic [DIM_W-1:0]       coded_width;
   logic [DIM_W-1:0]       coded_height;
   logic [FNUM_W-1:0]      decoded_frames;
   logic [CNT_W-1:0]       count_reg;

   header_word_type pending_headers[$];
   result_type      awaited_results[$];
   header_word_type on_wire;
   int              headers_queued;
   int              results_seen;
   int              errors;
   int              quiet_cycles;
   int              send_hold;
   int              recv_hold;
   logic            send_burst;
   logic            recv_burst;
   int unsigned     plan_width;
   int unsigned     plan_height;
   int              count_plan [PHASES];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned usable_surfaces();
      int unsigned n;
      n = count_reg;
      if (n > CAP_COUNT) begin
         n = CAP_COUNT;
      end
      if (n < MIN_COUNT) begin
         n = MIN_COUNT;
      end
      return n;
   endfunction

   function automatic void empty_slots();
      foreach (slot_surface[i]) begin
         slot_surface[i] = NO_SURFACE;
      end
   endfunction

   function automatic result_type resolve_surfaces(input header_word_type h);
      result_type             r;
      int unsigned            n;
      int unsigned            cand;
      int unsigned            pick;
      logic                   found;
      logic                   taken;
      logic [SLOT_DATA_W-1:0] held;
      r.status       = STATUS_OK;
      r.surface      = '0;
      r.display      = 1'b0;
      r.ref_surface0 = NO_SURFACE;
      r.ref_surface1 = NO_SURFACE;
      r.ref_surface2 = NO_SURFACE;
      r.frame_number = '0;
      n = usable_surfaces();
      case (h.cmd)
         CMD_DECODE: begin
            if (h.frame_width == '0 || h.frame_height == '0 ||
                h.frame_width > MAX_DIM || h.frame_height > MAX_DIM) begin
               r.status = STATUS_SIZE;
            end else if ((h.frame_width != coded_width || h.frame_height != coded_height)
                         && !h.key_frame) begin
               r.status = STATUS_SIZE;
            end else begin
               if (h.frame_width != coded_width || h.frame_height != coded_height) begin
                  empty_slots();
                  rr_cursor    = SURF_W'(n - 1);
                  coded_width  = h.frame_width;
                  coded_height = h.frame_height;
               end
               pick  = (rr_cursor + 1) % n;
               found = 1'b0;
               for (int unsigned t = 0; t < n; t++) begin
                  cand  = (rr_cursor + 1 + t) % n;
                  taken = 1'b0;
                  foreach (slot_surface[i]) begin
                     if (slot_surface[i] == cand) begin
                        taken = 1'b1;
                     end
                  end
                  if (!taken && !found) begin
                     pick  = cand;
                     found = 1'b1;
                  end
               end
               rr_cursor = SURF_W'(pick);
               if (!h.is_intra) begin
                  r.ref_surface0 = slot_surface[h.ref_idx0];
                  r.ref_surface1 = slot_surface[h.ref_idx1];
                  r.ref_surface2 = slot_surface[h.ref_idx2];
               end
               decoded_frames = decoded_frames + 1;
               if (decoded_frames == '0) begin
                  decoded_frames = 1;
               end
               r.frame_number = decoded_frames;
               for (int i = 0; i < REF_SLOTS; i++) begin
                  if (h.refresh_mask[i]) begin
                     slot_surface[i] = SLOT_DATA_W'(pick);
                  end
               end
               r.surface = rr_cursor;
               r.display = h.show_decoded;
            end
         end
         CMD_SHOW: begin
            held = slot_surface[h.show_slot];
            if (held == NO_SURFACE || held >= n) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.surface = held[SURF_W-1:0];
               r.display = 1'b1;
            end
         end
         CMD_FLUSH: begin
            empty_slots();
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic header_word_type random_header();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(header_word_type)-1:0];
   endfunction

   function automatic header_word_type decode_of(input logic key, input logic intra,
                                                 input int unsigned width,
                                                 input int unsigned height,
                                                 input logic [REF_SLOTS-1:0] mask);
      header_word_type h;
      h              = random_header();
      h.cmd          = CMD_DECODE;
      h.key_frame    = key;
      h.is_intra     = intra;
      h.frame_width  = DIM_W'(width);
      h.frame_height = DIM_W'(height);
      h.refresh_mask = mask;
      return h;
   endfunction

   function automatic header_word_type command_of(input logic [CMD_W-1:0] cmd,
                                                  input int unsigned slot);
      header_word_type h;
      h           = random_header();
      h.cmd       = cmd;
      h.show_slot = SLOT_IDX_W'(slot);
      return h;
   endfunction

   task automatic queue_header(input header_word_type h);
      pending_headers.push_back(h);
      headers_queued++;
   endtask

   task automatic queue_random_headers(input int count);
      header_word_type h;
      int unsigned     pick;
      for (int k = 0; k < count; k++) begin
         h    = random_header();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            h.cmd       = CMD_DECODE;
            h.key_frame = (plan_width == 0) || ($urandom_range(0, 9) == 0);
            if (h.key_frame && (plan_width == 0 || $urandom_range(0, 1) == 1)) begin
               plan_width  = $urandom_range(1, MAX_DIM);
               plan_height = $urandom_range(1, MAX_DIM);
            end
            h.frame_width  = DIM_W'(plan_width);
            h.frame_height = DIM_W'(plan_height);
            h.is_intra     = h.key_frame ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
               0: h.refresh_mask = '0;
               1: h.refresh_mask = '1;
               default: begin
               end
            endcase
         end else if (pick < 80) begin
            h.cmd = CMD_SHOW;
         end else if (pick < 86) begin
            h.cmd = CMD_FLUSH;
         end else if (pick < 90) begin
            h.cmd = CMD_UNUSED;
         end else begin
            h.cmd = CMD_DECODE;
            if ($urandom_range(0, 1) == 1) begin
               h.key_frame    = 1'b0;
               h.frame_width  = DIM_W'($urandom_range(1, MAX_DIM));
               h.frame_height = DIM_W'(plan_height);
            end else if ($urandom_range(0, 1) == 1) begin
               h.frame_width = '0;
            end else begin
               h.frame_width = DIM_W'($urandom_range(MAX_DIM + 1, DIM_CEILING));
            end
         end
         queue_header(h);
      end
   endtask

   task automatic wait_for_drain();
      while (results_seen < headers_queued) begin
         @(posedge clock);
      end
   endtask

   task automatic compare_field(input string field, input logic [FNUM_W-1:0] want,
                                input logic [FNUM_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      header_word_type upcoming;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_hold    <= 0;
         send_burst   <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(resolve_surfaces(on_wire));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_hold > 0) begin
               send_hold    <= send_hold - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_headers.size() != 0) begin
               upcoming            = pending_headers.pop_front();
               on_wire             <= upcoming;
               req_ch.cmd          <= upcoming.cmd;
               req_ch.key_frame    <= upcoming.key_frame;
               req_ch.is_intra     <= upcoming.is_intra;
               req_ch.ref_idx0     <= upcoming.ref_idx0;
               req_ch.ref_idx1     <= upcoming.ref_idx1;
               req_ch.ref_idx2     <= upcoming.ref_idx2;
               req_ch.refresh_mask <= upcoming.refresh_mask;
               req_ch.frame_width  <= upcoming.frame_width;
               req_ch.frame_height <= upcoming.frame_height;
               req_ch.show_decoded <= upcoming.show_decoded;
               req_ch.show_slot    <= upcoming.show_slot;
               req_ch.valid        <= 1'b1;
               if ($urandom_range(0, 31) == 0) begin
                  send_burst <= !send_burst;
               end
               send_hold <= send_burst ? 0 : $urandom_range(0, 7);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type  got;
      result_type  want;
      int unsigned stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_hold    <= 0;
         recv_burst   <= 1'b0;
      end else begin
         stall = recv_hold;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status       = rsp_ch.status;
            got.surface      = rsp_ch.surface;
            got.display      = rsp_ch.display;
            got.ref_surface0 = rsp_ch.ref_surface0;
            got.ref_surface1 = rsp_ch.ref_surface1;
            got.ref_surface2 = rsp_ch.ref_surface2;
            got.frame_number = rsp_ch.frame_number;
            results_seen++;
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: result word with no header outstanding, expected none, got %p",
                        $time, got);
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", want.status, got.status);
               compare_field("surface", want.surface, got.surface);
               compare_field("display", want.display, got.display);
               compare_field("ref_surface0", want.ref_surface0, got.ref_surface0);
               compare_field("ref_surface1", want.ref_surface1, got.ref_surface1);
               compare_field("ref_surface2", want.ref_surface2, got.ref_surface2);
               compare_field("frame_number", want.frame_number, got.frame_number);
            end
            if ($urandom_range(0, 31) == 0) begin
               recv_burst <= !recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_hold    <= stall - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            recv_hold    <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_DECODE;
      req_ch.key_frame    = 1'b0;
      req_ch.is_intra     = 1'b0;
      req_ch.ref_idx0     = '0;
      req_ch.ref_idx1     = '0;
      req_ch.ref_idx2     = '0;
      req_ch.refresh_mask = '0;
      req_ch.frame_width  = '0;
      req_ch.frame_height = '0;
      req_ch.show_decoded = 1'b0;
      req_ch.show_slot    = '0;
      rsp_ch.ready        = 1'b0;
      on_wire             = '0;
      headers_queued      = 0;
      results_seen        = 0;
      errors              = 0;
      quiet_cycles        = 0;
      send_hold           = 0;
      recv_hold           = 0;
      send_burst          = 1'b0;
      recv_burst          = 1'b0;
      plan_width          = 0;
      plan_height         = 0;

      count_reg = CNT_W'(RESET_COUNT);
      empty_slots();
      rr_cursor      = SURF_W'(usable_surfaces() - 1);
      coded_width    = '0;
      coded_height   = '0;
      decoded_frames = '0;

      count_plan = '{RESET_COUNT, 32, 2, 0, 1, 63, 33, 31, 3, 0, 0, 0};
      for (int p = PHASES - 3; p < PHASES; p++) begin
         count_plan[p] = $urandom_range(0, (1 << CNT_W) - 1);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= CNT_W'(count_plan[p]);
            @(posedge clock);
            csr_wr_en <= 1'b0;
            count_reg = CNT_W'(count_plan[p]);
         end
         for (int s = 0; s < REF_SLOTS; s++) begin
            queue_header(command_of(CMD_SHOW, s));
         end
         if (p == 0) begin
            // An inter frame straight after reset meets a stored size of zero.
            queue_header(decode_of(1'b0, 1'b0, 64, 48, '1));
            queue_header(decode_of(1'b1, 1'b1, 0, 48, '1));
            queue_header(decode_of(1'b1, 1'b1, 64, 0, '1));
            queue_header(decode_of(1'b1, 1'b1, MAX_DIM + 1, 48, '1));
            queue_header(decode_of(1'b1, 1'b1, DIM_CEILING, DIM_CEILING, '1));
            queue_header(decode_of(1'b1, 1'b1, MAX_DIM, MAX_DIM, '1));
            queue_header(decode_of(1'b0, 1'b0, MAX_DIM, MAX_DIM, '0));
            queue_header(decode_of(1'b0, 1'b0, MAX_DIM, MAX_DIM, 8'h01));
            queue_header(decode_of(1'b0, 1'b0, MAX_DIM, MAX_DIM, 8'h80));
            queue_header(command_of(CMD_SHOW, 0));
            queue_header(command_of(CMD_SHOW, 3));
            queue_header(decode_of(1'b0, 1'b0, 640, 480, '1));
            queue_header(decode_of(1'b1, 1'b0, 640, 480, 8'h02));
            queue_header(command_of(CMD_SHOW, 0));
            queue_header(command_of(CMD_FLUSH, 0));
            queue_header(command_of(CMD_SHOW, 1));
            queue_header(command_of(CMD_UNUSED, 0));
            queue_header(decode_of(1'b1, 1'b1, 640, 480, '1));
            queue_header(decode_of(1'b1, 1'b0, 1, 1, '1));
            queue_header(decode_of(1'b0, 1'b1, 1, 1, 8'h10));
         end
         queue_random_headers(RANDOM_PER_PHASE);
         // A keyframe and a run of single-slot refreshes push the surfaces up,
         // so that a lower count in the next phase leaves slots out of range.
         plan_width  = $urandom_range(1, MAX_DIM);
         plan_height = $urandom_range(1, MAX_DIM);
         queue_header(decode_of(1'b1, 1'b1, plan_width, plan_height, '1));
         for (int k = 0; k < 12; k++) begin
            queue_header(decode_of(1'b0, 1'b0, plan_width, plan_height,
                                   REF_SLOTS'(1 << (k % REF_SLOTS))));
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         errors++;
         $display("%0t: expected %0d more result words, got none", $time,
                  awaited_results.size());
      end
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vrsm_pkg.sv
rtl/core/vrsm_if.sv
rtl/core/vrsm_front.sv
rtl/core/vrsm_queue.sv
rtl/core/vrsm_back.sv
rtl/core/vp9_reference_surface_manager.sv
sim/testbench.sv
